/* rtl/agcm_pkg.sv */
// Package: shared types, constants and functions for the AES-128-GCM engine.
`timescale 1ns / 1ps
package agcm_pkg;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_AAD    = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_FINISH = 2'd3
  } req_t;

  localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
  localparam logic [2:0] CFG_KEY_LOW  = 3'd1;
  localparam logic [2:0] CFG_IV_HIGH  = 3'd2;
  localparam logic [2:0] CFG_IV_LOW   = 3'd3;
  localparam logic [2:0] CFG_DECRYPT  = 3'd4;
  localparam logic [2:0] CFG_EXP_HIGH = 3'd5;
  localparam logic [2:0] CFG_EXP_LOW  = 3'd6;

  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] GHASH_R = 8'he1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_bytes;
    logic        is_tag;
    logic        tag_ok;
  } out_word_t;

  // Control from sequencer to AES round unit.
  typedef struct packed {
    logic       load;
    logic       last;
    logic       step;
  } aes_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;  4'd4: r = 8'h08;
      4'd5: r = 8'h10;  4'd6: r = 8'h20;  4'd7: r = 8'h40;  4'd8: r = 8'h80;
      4'd9: r = GF_POLY; 4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // Mask of the leading n bytes of a 128-bit block, n already clamped to 16.
  function automatic logic [127:0] lead_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    return m;
  endfunction

endpackage

/* rtl/agcm_ram.sv */
// Module: generic single-port RAM with registered read.
`timescale 1ns / 1ps
module agcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/agcm_aes_round.sv */
// Module: AES round datapath, one round per cycle in which step is set; the 128-bit round key is applied whole.
`timescale 1ns / 1ps
module agcm_aes_round (
  input  logic                 clk,
  input  agcm_pkg::aes_ctl_t   ctl,
  input  logic [127:0]         load_data,
  input  logic [127:0]         rkey,
  output logic [127:0]         state
);
  import agcm_pkg::*;

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [127:0] mixed;
  logic [7:0]   a, b, c, d, e;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state[127 - 8 * i -: 8];
    for (int col = 0; col < 4; col++)
      for (int r = 0; r < 4; r++)
        t[4 * col + r] = sbox(s[4 * ((col + r) % 4) + r]);
    for (int col = 0; col < 4; col++) begin
      a = t[4 * col]; b = t[4 * col + 1]; c = t[4 * col + 2]; d = t[4 * col + 3];
      e = a ^ b ^ c ^ d;
      m[4 * col]     = a ^ e ^ mul2(a ^ b);
      m[4 * col + 1] = b ^ e ^ mul2(b ^ c);
      m[4 * col + 2] = c ^ e ^ mul2(c ^ d);
      m[4 * col + 3] = d ^ e ^ mul2(d ^ a);
    end
    for (int i = 0; i < 16; i++) mixed[127 - 8 * i -: 8] = ctl.last ? t[i] : m[i];
  end

  // State holds between rounds while the next round key is gathered.
  always_ff @(posedge clk) begin
    if (ctl.load)      state <= load_data ^ rkey;
    else if (ctl.step) state <= mixed ^ rkey;
  end
endmodule

/* rtl/agcm_ghash.sv */
// Module: GF(2^128) multiplier, eight bits of the operand per cycle while busy.
`timescale 1ns / 1ps
module agcm_ghash (
  input  logic         clk,
  input  logic         start,
  input  logic [127:0] x,
  input  logic [127:0] h,
  output logic [127:0] z,
  output logic         busy
);
  import agcm_pkg::*;

  logic [127:0] xs, v, zn, vn;
  logic [3:0]   cnt;

  always_comb begin
    zn = z;
    vn = v;
    for (int i = 0; i < 8; i++) begin
      if (xs[127 - i]) zn = zn ^ vn;
      vn = {1'b0, vn[127:1]} ^ (vn[0] ? {GHASH_R, 120'd0} : 128'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs <= x; v <= h; z <= '0; cnt <= '0; busy <= 1'b1;
    end else if (busy) begin
      xs <= {xs[119:0], 8'd0}; v <= vn; z <= zn;
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) busy <= 1'b0;
    end
  end
endmodule

/* rtl/aes128_gcm_stream_engine_top.sv */
// Module: AES-128-GCM streaming engine top level and sequencer.
//
//  channel  | signals                           | direction
//  ---------+-----------------------------------+----------
//  input    | in_valid, in_ready, in_word       | in
//  output   | out_valid, out_ready, out_word    | out
//  config   | cfg_we, cfg_index, cfg_data       | in
//
// Round keys come from RAM one word per cycle, so an AES round waits for all four of its
//   key words; a full pass is initial reads, 11 key additions and a final capture.
// Start: load and expand the key into RAM (44 words), then two passes (H, tag mask).
//   Text word: an AES pass, then a GHASH fold and the result.
// AAD and finish: a GHASH fold over the 16 bytes of the operand. Empty blocks do no work.
// The result sits in an output register; the next word is taken only after it drains.
// rst clears control and the hash/byte totals; round-key RAM is undefined until start.
`timescale 1ns / 1ps
module aes128_gcm_stream_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  agcm_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output agcm_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import agcm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_KEXP, S_KEXP_W, S_AES_RD, S_AES, S_GH_GO, S_GH_WAIT, S_DONE
  } st_t;

  // configuration
  logic [127:0] key, exp_tag;
  logic [95:0]  iv;
  logic         dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; iv <= '0; dec <= 1'b0; exp_tag <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key[127:64]    <= cfg_data;
        CFG_KEY_LOW:  key[63:0]      <= cfg_data;
        CFG_IV_HIGH:  iv[95:64]      <= cfg_data[31:0];
        CFG_IV_LOW:   iv[63:0]       <= cfg_data;
        CFG_DECRYPT:  dec            <= cfg_data[0];
        CFG_EXP_HIGH: exp_tag[127:64] <= cfg_data;
        CFG_EXP_LOW:  exp_tag[63:0]  <= cfg_data;
        default: ;
      endcase
    end
  end

  st_t          st;
  req_t         req;
  logic [127:0] din, mask;
  logic [4:0]   n;
  logic [127:0] hsub, tmask, acc;
  logic [31:0]  ctr;
  logic [60:0]  aad_b, txt_b;
  logic [1:0]   pass;       // start: 0 = H, 1 = tag mask; text: 2
  logic [5:0]   kidx;       // key expansion word index
  logic [31:0]  w1, w2, w3, w4; // last four expanded words
  logic [3:0]   rnd;
  logic [1:0]   col;        // round-key word being read
  logic [95:0]  rk_acc;
  logic         ram_we;
  logic [5:0]   ram_addr;
  logic [31:0]  ram_wd, ram_rd;
  aes_ctl_t     actl;
  logic [127:0] aes_in, rkey, aes_st;
  logic         gh_start, gh_busy;
  logic [127:0] gh_x, gh_z;
  logic [4:0]   nc;
  logic [31:0]  kexp_t;

  assign nc = (in_word.byte_count > 5'd16) ? 5'd16 : in_word.byte_count;
  assign in_ready = (st == S_IDLE) && !out_valid;

  agcm_ram #(.WIDTH(32), .DEPTH(44)) u_rk (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd));

  always_comb begin
    kexp_t = w4;
    if (kidx[1:0] == 2'd0)
      kexp_t = sub_word({w4[23:0], w4[31:24]}) ^ {rcon(kidx[5:2]), 24'd0};
  end

  // Key words arrive one per cycle; a round is applied once all four are in.
  assign ram_we   = (st == S_KEXP) || (st == S_KEXP_W);
  assign ram_wd   = (st == S_KEXP_W) ? (w1 ^ kexp_t) :
                    key[127 - 32 * kidx[1:0] -: 32];
  assign ram_addr = ram_we ? kidx : {rnd, col};
  assign rkey     = {rk_acc, ram_rd};

  logic aes_step;
  assign aes_step = (st == S_AES) && (col == 2'd0) && (rnd != 4'd0);

  assign actl.load = aes_step && (rnd == 4'd1);
  assign actl.last = (rnd == 4'd11);
  assign actl.step = aes_step;
  assign aes_in   = (pass == 2'd0) ? 128'd0 : {iv, (pass == 2'd1) ? 32'd1 : ctr};

  // GHASH picks up its operand in the cycle after it is registered.
  assign gh_start = (st == S_GH_GO);

  agcm_aes_round u_aes (
    .clk(clk), .ctl(actl), .load_data(aes_in), .rkey(rkey), .state(aes_st));

  agcm_ghash u_gh (
    .clk(clk), .start(gh_start), .x(gh_x), .h(hsub), .z(gh_z), .busy(gh_busy));

  logic [127:0] ks_out;
  assign ks_out = (din ^ aes_st) & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; out_valid <= 1'b0;
      acc <= '0; ctr <= '0; aad_b <= '0; txt_b <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (in_valid && in_ready) begin
          req  <= req_t'(in_word.req_type);
          n    <= nc;
          mask <= lead_mask(nc);
          din  <= {in_word.data_high, in_word.data_low} & lead_mask(nc);
          unique case (req_t'(in_word.req_type))
            REQ_START: begin kidx <= '0; st <= S_KEXP; end
            REQ_AAD: if (nc != 5'd0) begin
              gh_x <= acc ^ ({in_word.data_high, in_word.data_low} & lead_mask(nc));
              aad_b <= aad_b + 61'(nc); st <= S_GH_GO;
            end
            REQ_TEXT: if (nc != 5'd0) begin
              ctr <= ctr + 32'd1; pass <= 2'd2; rnd <= 4'd0; col <= 2'd0;
              txt_b <= txt_b + 61'(nc); st <= S_AES_RD;
            end
            REQ_FINISH: begin
              // length block: bit totals of AAD and text, 64 bits each
              gh_x <= acc ^ {aad_b, 3'd0, txt_b, 3'd0};
              st <= S_GH_GO;
            end
            default: ;
          endcase
        end
        S_KEXP: begin
          unique case (kidx[1:0])
            2'd0: w1 <= ram_wd; 2'd1: w2 <= ram_wd;
            2'd2: w3 <= ram_wd; default: w4 <= ram_wd;
          endcase
          kidx <= kidx + 6'd1;
          if (kidx == 6'd3) st <= S_KEXP_W;
        end
        S_KEXP_W: begin
          w1 <= w2; w2 <= w3; w3 <= w4; w4 <= ram_wd;
          kidx <= kidx + 6'd1;
          if (kidx == 6'd43) begin
            pass <= 2'd0; rnd <= 4'd0; col <= 2'd0; st <= S_AES_RD;
          end
        end
        S_AES_RD: begin col <= 2'd1; st <= S_AES; end
        S_AES: begin
          // read of word (rnd,col) issued; data of previous address now in ram_rd
          rk_acc <= {rk_acc[63:0], ram_rd};
          // last round is applied at (11,0); the state is final in the cycle after, at (11,1)
          if (rnd == 4'd11 && col == 2'd1) begin
            if (pass == 2'd0) begin
              hsub <= aes_st; pass <= 2'd1; rnd <= 4'd0; col <= 2'd0; st <= S_AES_RD;
            end else if (pass == 2'd1) begin
              tmask <= aes_st; acc <= '0; ctr <= 32'd1;
              aad_b <= '0; txt_b <= '0; st <= S_IDLE;
            end else begin
              out_word <= '{out_high: ks_out[127:64], out_low: ks_out[63:0],
                            out_bytes: n, is_tag: 1'b0, tag_ok: 1'b0};
              gh_x <= acc ^ (dec ? din : ks_out);
              st <= S_GH_GO;
            end
          end else if (col == 2'd3) begin
            col <= 2'd0; rnd <= rnd + 4'd1;
          end else begin
            col <= col + 2'd1;
          end
        end
        S_GH_GO: st <= S_GH_WAIT;
        S_GH_WAIT: if (!gh_busy) begin
          acc <= gh_z;
          st  <= S_DONE;
        end
        S_DONE: begin
          if (req == REQ_TEXT) out_valid <= 1'b1;
          else if (req == REQ_FINISH) begin
            out_valid <= 1'b1;
            out_word <= '{out_high: acc[127:64] ^ tmask[127:64],
                          out_low: acc[63:0] ^ tmask[63:0], out_bytes: 5'd16,
                          is_tag: 1'b1,
                          tag_ok: dec && ((acc ^ tmask) == exp_tag)};
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_word.req_type == REQ_START)) |=> !in_ready)
    else $error("second word taken while busy");
  assert property (@(posedge clk) disable iff (rst) gh_start |=> gh_busy)
    else $error("ghash did not start");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_word))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> st != S_IDLE)
    else $error("round key write while idle");
endmodule

/* verif/agcm_checker.sv */
// Checker for the GCM engine: mirrors the configuration, predicts every result and compares.
`timescale 1ns / 1ps
module agcm_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  agcm_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  agcm_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  errors,
  output int                  pending,
  output int                  results_seen,
  output int                  tags_seen
);
  import agcm_pkg::*;

  logic [7:0] sb [256];
  logic [63:0] key_hi, key_lo, iv_lo, exp_hi, exp_lo;
  logic [31:0] iv_hi;
  logic        dec;
  logic [31:0] rk [44];
  logic [127:0] h_key, t_mask, acc;
  logic [31:0] ctr;
  logic [60:0] aad_tot, txt_tot;
  out_word_t   result_q [$];

  initial begin
    sb = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
  end

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic expand_keys();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    rk[0] = key_hi[63:32]; rk[1] = key_hi[31:0];
    rk[2] = key_lo[63:32]; rk[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = rk[i - 1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb[t[31:24]] ^ rc, sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
        rc = xt(rc);
      end
      rk[i] = rk[i - 4] ^ t;
    end
  endtask

  // Block cipher on a 128-bit big-endian block; byte k sits at bits 127-8k.
  function automatic logic [127:0] cipher(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, c, d, e;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++)
            t[4 * col + row] = sb[s[4 * ((col + row) % 4) + row]];
        s = t;
        if (rnd < 10)
          for (int col = 0; col < 4; col++) begin
            a = s[4*col]; b = s[4*col+1]; c = s[4*col+2]; d = s[4*col+3];
            e = a ^ b ^ c ^ d;
            s[4*col]   ^= e ^ xt(a ^ b);
            s[4*col+1] ^= e ^ xt(b ^ c);
            s[4*col+2] ^= e ^ xt(c ^ d);
            s[4*col+3] ^= e ^ xt(d ^ a);
          end
      end
      for (int col = 0; col < 4; col++)
        for (int j = 0; j < 4; j++)
          s[4 * col + j] ^= rk[4 * rnd + col][31 - 8 * j -: 8];
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
    return r;
  endfunction

  // acc = (acc ^ blk) * H, bit-reflected GF(2^128)
  task automatic hash_fold(input logic [127:0] blk);
    logic [127:0] x, v, z;
    x = acc ^ blk; v = h_key; z = '0;
    for (int i = 0; i < 128; i++) begin
      if (x[127 - i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
    end
    acc = z;
  endtask

  task automatic predict(input in_word_t w);
    logic [4:0]   n;
    logic [127:0] m, d, ks, r;
    out_word_t    o;
    n = (w.byte_count > 5'd16) ? 5'd16 : w.byte_count;
    for (int i = 0; i < 16; i++) m[127 - 8 * i -: 8] = (i < n) ? 8'hff : 8'h00;
    d = {w.data_high, w.data_low} & m;
    case (req_t'(w.req_type))
      REQ_START: begin
        expand_keys();
        h_key = cipher('0);
        t_mask = cipher({iv_hi, iv_lo, 32'd1});
        ctr = 32'd1; acc = '0; aad_tot = '0; txt_tot = '0;
      end
      REQ_AAD: if (n != 0) begin
        hash_fold(d);
        aad_tot += 61'(n);
      end
      REQ_TEXT: if (n != 0) begin
        ctr += 32'd1;
        ks = cipher({iv_hi, iv_lo, ctr});
        r = (d ^ ks) & m;
        hash_fold(dec ? d : r);
        txt_tot += 61'(n);
        o = '{r[127:64], r[63:0], n, 1'b0, 1'b0};
        result_q.push_back(o);
      end
      default: begin
        hash_fold({aad_tot, 3'b0, txt_tot, 3'b0});
        r = acc ^ t_mask;
        o = '{r[127:64], r[63:0], 5'd16, 1'b1, dec && r == {exp_hi, exp_lo}};
        result_q.push_back(o);
      end
    endcase
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      key_hi <= '0; key_lo <= '0; iv_hi <= '0; iv_lo <= '0; dec <= 1'b0;
      exp_hi <= '0; exp_lo <= '0;
      errors <= 0; results_seen <= 0; tags_seen <= 0;
      acc = '0; ctr = '0; aad_tot = '0; txt_tot = '0;
      h_key = '0; t_mask = '0;
      for (int i = 0; i < 44; i++) rk[i] = '0;
      result_q.delete();
    end else begin
      if (cfg_we)
        case (cfg_index)
          CFG_KEY_HIGH: key_hi <= cfg_data;
          CFG_KEY_LOW:  key_lo <= cfg_data;
          CFG_IV_HIGH:  iv_hi  <= cfg_data[31:0];
          CFG_IV_LOW:   iv_lo  <= cfg_data;
          CFG_DECRYPT:  dec    <= cfg_data[0];
          CFG_EXP_HIGH: exp_hi <= cfg_data;
          CFG_EXP_LOW:  exp_lo <= cfg_data;
          default: ;
        endcase
      if (in_valid && in_ready) predict(in_word);
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result %h", $time, out_word);
        end else begin
          e = result_q.pop_front();
          results_seen <= results_seen + 1;
          if (out_word.is_tag) tags_seen <= tags_seen + 1;
          if (out_word !== e) begin
            errors <= errors + 1;
            $display("%0t: mismatch exp hi=%h lo=%h n=%0d tag=%b ok=%b", $time,
                     e.out_high, e.out_low, e.out_bytes, e.is_tag, e.tag_ok);
            $display("%0t:          got hi=%h lo=%h n=%0d tag=%b ok=%b", $time,
                     out_word.out_high, out_word.out_low, out_word.out_bytes,
                     out_word.is_tag, out_word.tag_ok);
          end
        end
      end
    end
  end
endmodule

/* verif/tb_top.sv */
// Testbench top: drives messages and configuration into the GCM engine and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
  import agcm_pkg::*;

  logic      clk, rst;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_word_t  in_word;
  out_word_t out_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int errors, pending, results_seen, tags_seen;
  int send_idle, recv_stall;   // percent chance per cycle
  int words_sent;

  aes128_gcm_stream_engine_top u_top (.*);

  agcm_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending, .results_seen, .tags_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random on the falling edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Drive one word and hold it until the engine takes it. Returns on the falling
  // edge after acceptance with valid still up; the next send drives its word or lowers it, quiesce lowers it.
  task automatic send(input req_t r, input logic [63:0] dh, input logic [63:0] dl,
                      input logic [4:0] n);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{r, dh, dl, n};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
  endtask

  // Drain all expected results, then let the engine finish an in-flight AAD word.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic load_session(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [31:0] ivh, input logic [63:0] ivl,
                              input logic dm, input logic [63:0] th, input logic [63:0] tl);
    quiesce();
    cfg_write(CFG_KEY_HIGH, kh);
    cfg_write(CFG_KEY_LOW, kl);
    cfg_write(CFG_IV_HIGH, {32'd0, ivh});
    cfg_write(CFG_IV_LOW, ivl);
    cfg_write(CFG_DECRYPT, {63'd0, dm});
    cfg_write(CFG_EXP_HIGH, th);
    cfg_write(CFG_EXP_LOW, tl);
    cfg_we <= 1'b0;
  endtask

  // A well-formed message: AAD blocks, text blocks, only the last of each may be partial.
  task automatic message();
    int na, nt;
    na = $urandom_range(3);
    nt = $urandom_range(5);
    send(REQ_START, rand64(), rand64(), 5'($urandom_range(31)));
    for (int i = 0; i < na; i++)
      send(REQ_AAD, rand64(), rand64(), (i == na - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
    for (int i = 0; i < nt; i++)
      send(REQ_TEXT, rand64(), rand64(), (i == nt - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
    send(REQ_FINISH, rand64(), rand64(), 5'($urandom_range(31)));
  endtask

  // Noise: any request type but start, any count, out-of-order blocks, extra finishes.
  task automatic noise_word();
    send(req_t'($urandom_range(1, 3)), rand64(), rand64(), 5'($urandom_range(31)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; in_word = '0;
    cfg_we = 1'b0; cfg_index = CFG_KEY_HIGH; cfg_data = '0;
    send_idle = 0; recv_stall = 0; words_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: all-zero config first, then all-ones with decrypt, then a zero key with decrypt.
    send(REQ_START, '1, '1, 5'd31);           // start ignores data and count
    send(REQ_AAD, '1, '1, 5'd0);              // empty block: no effect
    send(REQ_AAD, 64'h0123456789abcdef, '1, 5'd5);
    send(REQ_TEXT, '0, '0, 5'd0);             // empty text: no result
    send(REQ_TEXT, '1, '1, 5'd16);
    send(REQ_TEXT, '1, '1, 5'd31);            // oversized count clamps to 16
    send(REQ_TEXT, '1, '1, 5'd9);             // partial, then another block after it
    send(REQ_TEXT, 64'h8000000000000001, '0, 5'd1);
    send(REQ_AAD, '1, '1, 5'd16);             // AAD after text
    send(REQ_FINISH, '1, '1, 5'd16);
    send(REQ_FINISH, '0, '0, 5'd0);           // repeated finish
    load_session('1, '1, '1, '1, 1'b1, '1, '1);
    send(REQ_START, '0, '0, 5'd0);
    send(REQ_TEXT, '0, '0, 5'd16);
    send(REQ_TEXT, '1, '1, 5'd8);
    send(REQ_FINISH, '0, '0, 5'd0);
    // Decrypt with a matching tag: known tag of a zero key and nonce with no data.
    load_session('0, '0, '0, '0, 1'b1, 64'h58e2fccefa7e3061, 64'h367f1d57a4e7455a);
    send(REQ_START, '0, '0, 5'd0);
    send(REQ_FINISH, '0, '0, 5'd0);

    // Random sessions through the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 78) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 8 : 78) : 0;
      while (words_sent < 20 + 225 * (ph + 1)) begin
        if ($urandom_range(5) == 0)
          load_session(rand64(), rand64(), $urandom, rand64(), 1'($urandom_range(1)),
                       rand64(), rand64());
        message();
        if ($urandom_range(4) == 0) noise_word();
      end
    end

    quiesce();
    $display("tb_top: %0d words sent, %0d results checked, %0d of them tags",
             words_sent, results_seen, tags_seen);
    $display("tb_top: both modes, empty/partial/oversized blocks, order noise, four idle mixes");
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Slowest run: ~1000 words, each with engine work and long stalls, stays far below this.
  initial begin
    #20ms;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
